>>> rtl/mmt_pkg.sv
// Package for the 4x4 outer-product matrix tile accumulator.
// Holds the fixed tile geometry and the row index type.
// No dependencies.
package mmt_pkg;

	// Tile is fixed at four rows by four columns
	localparam int TILE     = 4;
	localparam int TILE_SQ  = TILE * TILE;
	localparam int ROW_W    = 2;

	typedef logic [ROW_W-1:0] row_idx_t;

	// Index of the final row in a tile
	localparam row_idx_t ROW_LAST = row_idx_t'(TILE - 1);

endpackage

>>> rtl/matmul_tile_4x4_accumulate_core.sv
// Top level of the 4x4 outer-product matrix tile accumulator.
// Depends on mmt_pkg (tile geometry, row index type).
//
// Each accepted request is one step k along the shared dimension: four A
// values (tile rows) and four B values (tile columns), signed fixed point.
// All sixteen products are formed in parallel and added exactly into
// ACC_WIDTH-bit accumulators, wrapping modulo 2^ACC_WIDTH. A request with
// last_step set adds its products, copies the finished tile into an output
// bank and clears the accumulators; the bank then delivers four results, row
// 0 to row 3, last_row marking row 3. The block takes one request per cycle
// while in_stall is low. The first result is presented once the last step
// has passed the input register and the product register and the accumulate
// has loaded the output bank, and can be taken at the following edge. The
// output bank holds one tile and drains one row per cycle while out_stall is
// low, so a last step that reaches the accumulators while the previous tile
// is still draining holds in_stall high until the final row of that tile is
// taken. Tiles of depth four or more thus run at one step per cycle with a
// free-flowing output.
module matmul_tile_4x4_accumulate_core #(
	parameter int DATA_WIDTH = 16,
	parameter int ACC_WIDTH  = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Step request
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] a_0,
	input  logic signed [DATA_WIDTH-1:0] a_1,
	input  logic signed [DATA_WIDTH-1:0] a_2,
	input  logic signed [DATA_WIDTH-1:0] a_3,
	input  logic signed [DATA_WIDTH-1:0] b_0,
	input  logic signed [DATA_WIDTH-1:0] b_1,
	input  logic signed [DATA_WIDTH-1:0] b_2,
	input  logic signed [DATA_WIDTH-1:0] b_3,
	input  logic                         last_step,
	// Row result request
	output logic                         out_valid,
	input  logic                         out_stall,
	output mmt_pkg::row_idx_t            row_index,
	output logic signed [ACC_WIDTH-1:0]  c_0,
	output logic signed [ACC_WIDTH-1:0]  c_1,
	output logic signed [ACC_WIDTH-1:0]  c_2,
	output logic signed [ACC_WIDTH-1:0]  c_3,
	output logic                         last_row
);
	import mmt_pkg::*;

	localparam int PROD_W = 2 * DATA_WIDTH;

	// Input register stage
	logic                         vld_s1;
	logic                         last_s1;
	logic signed [DATA_WIDTH-1:0] a_s1 [TILE];
	logic signed [DATA_WIDTH-1:0] b_s1 [TILE];

	// Product stage
	logic                         vld_s2;
	logic                         last_s2;
	logic signed [PROD_W-1:0]     prod_s2 [TILE_SQ];

	// Accumulators and output bank
	logic signed [ACC_WIDTH-1:0]  acc_q  [TILE_SQ];
	logic signed [ACC_WIDTH-1:0]  sum    [TILE_SQ];
	logic signed [ACC_WIDTH-1:0]  bank_q [TILE_SQ];
	logic                         bank_vld_q;
	row_idx_t                     row_q;

	logic bank_free;
	logic adv;
	logic dump;
	logic take;
	logic acc_zero;

	// Pipeline control: only a tile dump into a busy bank holds the pipe
	assign take      = bank_vld_q & ~out_stall;
	assign bank_free = ~bank_vld_q | (take & (row_q == ROW_LAST));
	assign adv       = ~(vld_s2 & last_s2 & ~bank_free);
	assign dump      = vld_s2 & last_s2 & bank_free;
	assign in_stall  = ~adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1[0] <= a_0;
			a_s1[1] <= a_1;
			a_s1[2] <= a_2;
			a_s1[3] <= a_3;
			b_s1[0] <= b_0;
			b_s1[1] <= b_1;
			b_s1[2] <= b_2;
			b_s1[3] <= b_3;
			last_s1 <= last_step;
		end
	end

	// Sixteen parallel products, registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			for (int r = 0; r < TILE; r++) begin
				for (int c = 0; c < TILE; c++) begin
					prod_s2[r*TILE + c] <= PROD_W'(a_s1[r] * b_s1[c]);
				end
			end
		end
	end

	// Accumulate: products sign-extended or truncated to accumulator width
	always_comb begin
		for (int i = 0; i < TILE_SQ; i++) begin
			sum[i] = acc_q[i] + ACC_WIDTH'(prod_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TILE_SQ; i++) begin
				acc_q[i] <= '0;
			end
		end else if (vld_s2 && adv) begin
			for (int i = 0; i < TILE_SQ; i++) begin
				acc_q[i] <= last_s2 ? '0 : sum[i];
			end
		end
	end

	// Output bank control: row counter and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_vld_q <= 1'b0;
			row_q      <= '0;
		end else if (dump) begin
			bank_vld_q <= 1'b1;
			row_q      <= '0;
		end else if (take) begin
			row_q <= row_q + row_idx_t'(1);
			if (row_q == ROW_LAST) begin
				bank_vld_q <= 1'b0;
			end
		end
	end

	// Output bank data: load whole tile, shift rows up as each is taken
	always_ff @(posedge clk) begin
		if (dump) begin
			for (int i = 0; i < TILE_SQ; i++) begin
				bank_q[i] <= sum[i];
			end
		end else if (take) begin
			for (int i = 0; i < TILE_SQ - TILE; i++) begin
				bank_q[i] <= bank_q[i + TILE];
			end
		end
	end

	// Result ports come from the bank's front row
	assign out_valid = bank_vld_q;
	assign row_index = row_q;
	assign c_0       = bank_q[0];
	assign c_1       = bank_q[1];
	assign c_2       = bank_q[2];
	assign c_3       = bank_q[3];
	assign last_row  = (row_q == ROW_LAST);

	always_comb begin
		acc_zero = 1'b1;
		for (int i = 0; i < TILE_SQ; i++) begin
			if (acc_q[i] != '0) begin
				acc_zero = 1'b0;
			end
		end
	end

	// Rows leave in order, one step per taken result
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		take && (row_q != ROW_LAST) |=> out_valid && (row_q == $past(row_q) + row_idx_t'(1)))
		else $error("tile rows out of order");

	// Input is held back only by a finished tile waiting for the bank
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s2 && last_s2 && bank_vld_q)
		else $error("input stalled without a pending tile");

	// A dumped tile leaves the accumulators clear and the bank at row 0
	a_dump_clear: assert property (@(posedge clk) disable iff (!arst_n)
		dump |=> acc_zero && out_valid && (row_q == '0))
		else $error("accumulators not cleared after tile dump");

endmodule
